### design/lbd_pkg.sv
package lbd_pkg;

    // samples that make one group, and the ladder reading width
    localparam int SAMPLES_PER_UPDATE = 3;
    localparam int ADC_BITS           = 12;

    localparam int GROUP_CNT_W = (SAMPLES_PER_UPDATE > 1) ? $clog2(SAMPLES_PER_UPDATE) : 1;
    localparam logic [GROUP_CNT_W-1:0] GROUP_LAST = GROUP_CNT_W'(SAMPLES_PER_UPDATE - 1);

    localparam int NUM_BUTTONS = 7;
    localparam int TIME_W      = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int LEVEL_W     = 12;
    localparam int DEBOUNCE_W  = 16;

    // button index that an inject ignores
    localparam logic [2:0] BUTTON_NONE = 3'd7;

    typedef logic [NUM_BUTTONS-1:0] mask_t;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_INJECT = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NO_BUTTON_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LADDER1_THR_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LADDER1_THR_B   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LADDER1_THR_C   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LADDER2_THR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_BAND      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 3'd6;

    // decoded sample held between the two register stages
    typedef struct packed {
        cmd_t                  cmd;
        mask_t                 mask;
        logic [TIME_W-1:0]     now_ms;
        logic [2:0]            button;
    } sample_t;

endpackage

### design/ladder_button_debouncer.sv
// Ladder button decoder with group sampling and debounce. Every word on the s_ channel is
// decoded in the first stage into a 7-bit button mask (ladder 1 gives buttons 0-3,
// ladder 2 gives buttons 4-5, power_low gives button 6); readings within guard_band of a
// range edge count as no button. The second stage collects SAMPLES_PER_UPDATE sample words
// into a group, runs stable groups through the debounce timer and puts one result word on
// the m_ channel per completed group. Inject and flush words, and samples that do not close
// a group, give no result. Decoded words and results are both registered, and one word is
// taken every cycle while m_ready keeps up, set by the single state update in the second
// stage. Configuration is written through cfg_wr_en/cfg_index/cfg_data, by the user only
// while idle; the block does not enforce this. Writes to index 7 are ignored.
module ladder_button_debouncer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [lbd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lbd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_command,
    input  logic [lbd_pkg::ADC_BITS-1:0]          s_adc_ladder1,
    input  logic [lbd_pkg::ADC_BITS-1:0]          s_adc_ladder2,
    input  logic                                  s_power_low,
    input  logic [lbd_pkg::TIME_W-1:0]            s_now_ms,
    input  logic [2:0]                            s_button,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lbd_pkg::NUM_BUTTONS-1:0]       m_pressed,
    output logic [lbd_pkg::NUM_BUTTONS-1:0]       m_released,
    output logic [lbd_pkg::NUM_BUTTONS-1:0]       m_held_now,
    output logic [lbd_pkg::TIME_W-1:0]            m_held_ms,
    output logic                                  m_reading_stable
);

    // configuration registers
    logic [lbd_pkg::LEVEL_W-1:0]    no_button_level_reg;
    logic [lbd_pkg::LEVEL_W-1:0]    thr_a_reg;
    logic [lbd_pkg::LEVEL_W-1:0]    thr_b_reg;
    logic [lbd_pkg::LEVEL_W-1:0]    thr_c_reg;
    logic [lbd_pkg::LEVEL_W-1:0]    thr2_reg;
    logic [lbd_pkg::LEVEL_W-1:0]    guard_reg;
    logic [lbd_pkg::DEBOUNCE_W-1:0] debounce_ms_reg;

    // first stage: decoded sample word
    logic               s1_valid_reg;
    lbd_pkg::sample_t   s1_reg;
    lbd_pkg::sample_t   s1_next;
    logic               s1_fire;

    // debounce and group state
    lbd_pkg::mask_t                     debounced_reg, debounced_next;
    lbd_pkg::mask_t                     last_reading_reg, last_reading_next;
    lbd_pkg::mask_t                     pending_reg, pending_next;
    logic [lbd_pkg::TIME_W-1:0]         dstart_reg, dstart_next;
    logic [lbd_pkg::TIME_W-1:0]         pstart_reg, pstart_next;
    logic [lbd_pkg::TIME_W-1:0]         pfinish_reg, pfinish_next;
    lbd_pkg::mask_t                     gfirst_reg, gfirst_next;
    logic                               gmismatch_reg, gmismatch_next;
    logic [lbd_pkg::GROUP_CNT_W-1:0]    gcount_reg, gcount_next;
    logic [lbd_pkg::TIME_W-1:0]         gtime_reg, gtime_next;

    // result register
    logic                               m_valid_reg;
    lbd_pkg::mask_t                     pressed_reg, pressed_next;
    lbd_pkg::mask_t                     released_reg, released_next;
    lbd_pkg::mask_t                     held_now_reg;
    logic [lbd_pkg::TIME_W-1:0]         held_ms_reg, held_ms_next;
    logic                               stable_reg, stable_next;
    logic                               result_next;

    // {in range, too close to an edge}
    function automatic logic [1:0] range_check(
        input logic [lbd_pkg::ADC_BITS-1:0] v,
        input logic [lbd_pkg::LEVEL_W-1:0]  hi,
        input logic [lbd_pkg::LEVEL_W-1:0]  lo,
        input logic                         bottom,
        input logic [lbd_pkg::LEVEL_W-1:0]  g
    );
        logic in_rng;
        logic reject;
        in_rng = (bottom || (lo < v)) && (v <= hi);
        reject = ((hi - v) < g) || (!bottom && ((v - lo) < g));
        return {in_rng, reject};
    endfunction

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            no_button_level_reg <= 12'd3800;
            thr_a_reg           <= 12'd3100;
            thr_b_reg           <= 12'd2090;
            thr_c_reg           <= 12'd750;
            thr2_reg            <= 12'd1120;
            guard_reg           <= 12'd50;
            debounce_ms_reg     <= 16'd5;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lbd_pkg::CFG_NO_BUTTON_LEVEL: no_button_level_reg <= cfg_data[11:0];
                lbd_pkg::CFG_LADDER1_THR_A:   thr_a_reg           <= cfg_data[11:0];
                lbd_pkg::CFG_LADDER1_THR_B:   thr_b_reg           <= cfg_data[11:0];
                lbd_pkg::CFG_LADDER1_THR_C:   thr_c_reg           <= cfg_data[11:0];
                lbd_pkg::CFG_LADDER2_THR:     thr2_reg            <= cfg_data[11:0];
                lbd_pkg::CFG_GUARD_BAND:      guard_reg           <= cfg_data[11:0];
                lbd_pkg::CFG_DEBOUNCE_MS:     debounce_ms_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage 1: ladder decode from the input ports
    // ---------------------------------------------------------------
    logic [1:0] l1_r0, l1_r1, l1_r2, l1_r3, l2_r0, l2_r1;
    lbd_pkg::mask_t sample_mask;

    always_comb begin
        l1_r0 = range_check(s_adc_ladder1, no_button_level_reg, thr_a_reg, 1'b0, guard_reg);
        l1_r1 = range_check(s_adc_ladder1, thr_a_reg, thr_b_reg, 1'b0, guard_reg);
        l1_r2 = range_check(s_adc_ladder1, thr_b_reg, thr_c_reg, 1'b0, guard_reg);
        l1_r3 = range_check(s_adc_ladder1, thr_c_reg, thr_c_reg, 1'b1, guard_reg);
        l2_r0 = range_check(s_adc_ladder2, no_button_level_reg, thr2_reg, 1'b0, guard_reg);
        l2_r1 = range_check(s_adc_ladder2, thr2_reg, thr2_reg, 1'b1, guard_reg);

        sample_mask = '0;
        // first range that holds the reading wins, guard band may still veto it
        if (l1_r0[1]) begin
            sample_mask[0] = !l1_r0[0];
        end else if (l1_r1[1]) begin
            sample_mask[1] = !l1_r1[0];
        end else if (l1_r2[1]) begin
            sample_mask[2] = !l1_r2[0];
        end else if (l1_r3[1]) begin
            sample_mask[3] = !l1_r3[0];
        end
        if (l2_r0[1]) begin
            sample_mask[4] = !l2_r0[0];
        end else if (l2_r1[1]) begin
            sample_mask[5] = !l2_r1[0];
        end
        sample_mask[6] = s_power_low;

        s1_next.cmd    = lbd_pkg::cmd_t'(s_command);
        s1_next.mask   = sample_mask;
        s1_next.now_ms = s_now_ms;
        s1_next.button = s_button;
    end

    // stage 1 moves on whenever the result register is free or being drained
    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_reg <= s1_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: grouping, debounce and result
    // ---------------------------------------------------------------
    lbd_pkg::mask_t             g_first;
    logic                       g_mismatch;
    logic [lbd_pkg::TIME_W-1:0] g_time;
    logic [lbd_pkg::TIME_W-1:0] since_change;
    lbd_pkg::mask_t             new_press;
    lbd_pkg::mask_t             new_release;
    logic                       edge_ok;

    always_comb begin
        debounced_next    = debounced_reg;
        last_reading_next = last_reading_reg;
        pending_next      = pending_reg;
        dstart_next       = dstart_reg;
        pstart_next       = pstart_reg;
        pfinish_next      = pfinish_reg;
        gfirst_next       = gfirst_reg;
        gmismatch_next    = gmismatch_reg;
        gcount_next       = gcount_reg;
        gtime_next        = gtime_reg;
        result_next       = 1'b0;
        pressed_next      = '0;
        released_next     = '0;
        stable_next       = 1'b0;
        held_ms_next      = '0;

        // group so far, including this sample
        if (gcount_reg == '0) begin
            g_first    = s1_reg.mask;
            g_mismatch = 1'b0;
            g_time     = s1_reg.now_ms;
        end else begin
            g_first    = gfirst_reg;
            g_mismatch = gmismatch_reg || (s1_reg.mask != gfirst_reg);
            g_time     = gtime_reg;
        end

        since_change = '0;
        new_press    = '0;
        new_release  = '0;
        edge_ok      = 1'b0;

        case (s1_reg.cmd)
            lbd_pkg::CMD_INJECT: begin
                if (s1_reg.button != lbd_pkg::BUTTON_NONE) begin
                    pending_next = pending_reg | lbd_pkg::mask_t'(7'd1 << s1_reg.button);
                end
            end
            lbd_pkg::CMD_FLUSH: begin
                debounced_next    = s1_reg.mask;
                last_reading_next = s1_reg.mask;
                pending_next      = '0;
                dstart_next       = s1_reg.now_ms;
                pstart_next       = s1_reg.now_ms;
                pfinish_next      = s1_reg.now_ms;
                gcount_next       = '0;
                gmismatch_next    = 1'b0;
            end
            lbd_pkg::CMD_SAMPLE: begin
                gfirst_next    = g_first;
                gmismatch_next = g_mismatch;
                gtime_next     = g_time;
                if (gcount_reg == lbd_pkg::GROUP_LAST) begin
                    gcount_next = '0;
                    result_next = 1'b1;
                    stable_next = !g_mismatch;
                    if (!g_mismatch) begin
                        // a changed reading restarts the debounce timer
                        if (g_first != last_reading_reg) begin
                            dstart_next       = g_time;
                            last_reading_next = g_first;
                        end
                        since_change = g_time - dstart_next;
                        edge_ok = (since_change > {16'd0, debounce_ms_reg})
                                  && (g_first != debounced_reg);
                        if (edge_ok) begin
                            new_press   = g_first & ~debounced_reg;
                            new_release = debounced_reg & ~g_first;
                            if ((new_press != '0) && (debounced_reg == '0)) begin
                                pstart_next = g_time;
                            end
                            if ((new_release != '0) && (g_first == '0)) begin
                                pfinish_next = g_time;
                            end
                            debounced_next = g_first;
                        end
                    end
                    pressed_next  = new_press | pending_reg;
                    released_next = new_release;
                    pending_next  = '0;
                    held_ms_next  = (debounced_next != '0) ? (s1_reg.now_ms - pstart_next)
                                                           : (pfinish_next - pstart_next);
                end else begin
                    gcount_next = gcount_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounced_reg    <= '0;
            last_reading_reg <= '0;
            pending_reg      <= '0;
            dstart_reg       <= '0;
            pstart_reg       <= '0;
            pfinish_reg      <= '0;
            gfirst_reg       <= '0;
            gmismatch_reg    <= 1'b0;
            gcount_reg       <= '0;
            gtime_reg        <= '0;
        end else if (s1_fire) begin
            debounced_reg    <= debounced_next;
            last_reading_reg <= last_reading_next;
            pending_reg      <= pending_next;
            dstart_reg       <= dstart_next;
            pstart_reg       <= pstart_next;
            pfinish_reg      <= pfinish_next;
            gfirst_reg       <= gfirst_next;
            gmismatch_reg    <= gmismatch_next;
            gcount_reg       <= gcount_next;
            gtime_reg        <= gtime_next;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && result_next) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && result_next) begin
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            held_now_reg <= debounced_next;
            held_ms_reg  <= held_ms_next;
            stable_reg   <= stable_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pressed        = pressed_reg;
    assign m_released       = released_reg;
    assign m_held_now       = held_now_reg;
    assign m_held_ms        = held_ms_reg;
    assign m_reading_stable = stable_reg;

endmodule

### dv/ladder_button_debouncer_tb.sv
module ladder_button_debouncer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 200;     // input words per random phase, nop words not counted
    localparam int DRAIN_CYCLES = 8;       // margin for the last words to leave the pipeline
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SCRIPT_LEN   = 25;

    // one input word as the block sees it
    typedef struct packed {
        lbd_pkg::cmd_t cmd;
        logic [11:0]   adc1;
        logic [11:0]   adc2;
        logic          pwr;
        logic [31:0]   now;
        logic [2:0]    button;
    } sample_word_t;

    // one result word
    typedef struct packed {
        lbd_pkg::mask_t pressed;
        lbd_pkg::mask_t released;
        lbd_pkg::mask_t held;
        logic [31:0]    held_ms;
        logic           stable;
    } report_t;

    // directed row: word to send, and a hand-written result where it is obvious
    typedef struct packed {
        sample_word_t word;
        bit           typed;
        report_t      want;
    } script_row_t;

    // one full register setting
    typedef struct packed {
        logic [15:0] level;
        logic [15:0] thr_a;
        logic [15:0] thr_b;
        logic [15:0] thr_c;
        logic [15:0] thr_2;
        logic [15:0] guard;
        logic [15:0] debounce;
    } cfg_set_t;

    localparam report_t NO_REPORT = '0;

    // directed words, all under the reset register values
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // idle ladders at time zero: an all-quiet stable group
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 1'b0, 32'd0, 3'd0}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 1'b0, 32'd0, 3'd0}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 1'b0, 32'd0, 3'd0}, 1'b1,
          '{7'h00, 7'h00, 7'h00, 32'd0, 1'b1}},
        // inject button 3, the out-of-range button is dropped, a nop does nothing
        '{'{lbd_pkg::CMD_INJECT, 12'd0, 12'd0, 1'b0, 32'd0, 3'd3}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_INJECT, 12'd0, 12'd0, 1'b0, 32'd0, lbd_pkg::BUTTON_NONE},
          1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_NOP, 12'd0, 12'd0, 1'b1, 32'd77, 3'd5}, 1'b0, NO_REPORT},
        // power pressed: new reading starts the timer, only the injected press shows
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 1'b1, 32'd100, 3'd0}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 1'b1, 32'd100, 3'd0}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 1'b1, 32'd100, 3'd0}, 1'b1,
          '{7'h08, 7'h00, 7'h00, 32'd0, 1'b1}},
        // unstable group: open bottom ranges and a reading on a guarded threshold
        '{'{lbd_pkg::CMD_SAMPLE, 12'd0, 12'd4095, 1'b0, 32'd110, 3'd0}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd0, 1'b0, 32'd111, 3'd0}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd3100, 12'd3101, 1'b0, 32'd112, 3'd0}, 1'b1,
          '{7'h00, 7'h00, 7'h00, 32'd0, 1'b0}},
        // power still held after the debounce time: press edge
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 1'b1, 32'd200, 3'd0}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 1'b1, 32'd201, 3'd0}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 1'b1, 32'd202, 3'd0}, 1'b0, NO_REPORT},
        // button 2 added just before the time wraps, accepted just after
        '{'{lbd_pkg::CMD_SAMPLE, 12'd2000, 12'd4095, 1'b1, 32'hFFFF_FFF0, 3'd0},
          1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd2000, 12'd4095, 1'b1, 32'hFFFF_FFF1, 3'd0},
          1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd2000, 12'd4095, 1'b1, 32'hFFFF_FFF2, 3'd0},
          1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd2000, 12'd4095, 1'b1, 32'h0000_0005, 3'd0},
          1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd2000, 12'd4095, 1'b1, 32'h0000_0006, 3'd0},
          1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd2000, 12'd4095, 1'b1, 32'h0000_0007, 3'd0},
          1'b0, NO_REPORT},
        // flush onto both bottom buttons, then readings inside the guard bands
        '{'{lbd_pkg::CMD_FLUSH, 12'd0, 12'd0, 1'b0, 32'hFFFF_FFFF, 3'd6}, 1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd799, 12'd1121, 1'b0, 32'hFFFF_FFFF, 3'd0},
          1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd799, 12'd1121, 1'b0, 32'hFFFF_FFFF, 3'd0},
          1'b0, NO_REPORT},
        '{'{lbd_pkg::CMD_SAMPLE, 12'd799, 12'd1121, 1'b0, 32'hFFFF_FFFF, 3'd0},
          1'b0, NO_REPORT}
    };

    // block ports, the driven inputs all known from time zero
    logic                            aclk             = 1'b0;
    logic                            aresetn          = 1'b0;
    logic                            cfg_wr_en        = 1'b0;
    logic [lbd_pkg::CFG_IDX_W-1:0]   cfg_index        = '0;
    logic [lbd_pkg::CFG_DATA_W-1:0]  cfg_data         = '0;
    logic                            s_valid          = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_command        = lbd_pkg::CMD_SAMPLE;
    logic [lbd_pkg::ADC_BITS-1:0]    s_adc_ladder1    = '0;
    logic [lbd_pkg::ADC_BITS-1:0]    s_adc_ladder2    = '0;
    logic                            s_power_low      = 1'b0;
    logic [lbd_pkg::TIME_W-1:0]      s_now_ms         = '0;
    logic [2:0]                      s_button         = '0;
    logic                            m_valid;
    logic                            m_ready          = 1'b1;
    logic [lbd_pkg::NUM_BUTTONS-1:0] m_pressed;
    logic [lbd_pkg::NUM_BUTTONS-1:0] m_released;
    logic [lbd_pkg::NUM_BUTTONS-1:0] m_held_now;
    logic [lbd_pkg::TIME_W-1:0]      m_held_ms;
    logic                            m_reading_stable;

    // register copies used for prediction
    logic [11:0] lvl_no_button = 12'd3800;
    logic [11:0] lvl_a         = 12'd3100;
    logic [11:0] lvl_b         = 12'd2090;
    logic [11:0] lvl_c         = 12'd750;
    logic [11:0] lvl_2         = 12'd1120;
    logic [11:0] guard_width   = 12'd50;
    logic [15:0] debounce_len  = 16'd5;

    // predicted block state, zero after reset
    lbd_pkg::mask_t deb_mask     = '0;
    lbd_pkg::mask_t last_read    = '0;
    lbd_pkg::mask_t inject_queue = '0;
    lbd_pkg::mask_t grp_first    = '0;
    bit             grp_unstable = 1'b0;
    int             grp_fill     = 0;
    logic [31:0]    deb_start    = '0;
    logic [31:0]    press_start  = '0;
    logic [31:0]    press_finish = '0;
    logic [31:0]    grp_time     = '0;

    report_t     reports_due [$];
    report_t     front;
    int          mismatches  = 0;
    int          cycle_count = 0;
    bit          idle_en     = 1'b1;
    int          stall_left  = 0;

    ladder_button_debouncer i_dut (.*);

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // hard stop if the run hangs or results go missing
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL ladder_button_debouncer");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts while idling is on
    always @(negedge aclk) begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_en && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 16);
        m_ready <= (stall_left == 0);
    end

    // range index of one ladder reading, -1 for no button or inside a guard band
    function automatic int ladder_range(input int v, input int tops [4], input int n);
        int hi;
        int lo;
        int g;
        bit bottom;
        g = int'(guard_width);
        for (int i = 0; i < n; i++) begin
            hi     = tops[i];
            bottom = (i == n - 1);
            lo     = bottom ? 0 : tops[i + 1];
            if ((bottom || lo < v) && v <= hi) begin
                if (hi - v < g) return -1;
                if (!bottom && v - lo < g) return -1;
                return i;
            end
        end
        return -1;
    endfunction

    // button mask of one sample word
    function automatic lbd_pkg::mask_t ladder_mask(input sample_word_t w);
        int             tops1 [4];
        int             tops2 [4];
        int             b;
        lbd_pkg::mask_t m;
        tops1 = '{int'(lvl_no_button), int'(lvl_a), int'(lvl_b), int'(lvl_c)};
        tops2 = '{int'(lvl_no_button), int'(lvl_2), 0, 0};
        m = '0;
        b = ladder_range(int'(w.adc1), tops1, 4);
        if (b >= 0) m[b] = 1'b1;
        b = ladder_range(int'(w.adc2), tops2, 2);
        if (b >= 0) m[b + 4] = 1'b1;
        if (w.pwr) m[6] = 1'b1;
        return m;
    endfunction

    // advance the predicted state by one accepted word, 1 when a result is due
    function automatic bit decode_and_debounce(input sample_word_t w, output report_t r);
        lbd_pkg::mask_t m;
        lbd_pkg::mask_t pressed;
        lbd_pkg::mask_t released;
        r = NO_REPORT;
        case (w.cmd)
            lbd_pkg::CMD_INJECT: begin
                if (w.button != lbd_pkg::BUTTON_NONE) inject_queue[w.button] = 1'b1;
                return 1'b0;
            end
            lbd_pkg::CMD_FLUSH: begin
                m            = ladder_mask(w);
                deb_mask     = m;
                last_read    = m;
                inject_queue = '0;
                deb_start    = w.now;
                press_start  = w.now;
                press_finish = w.now;
                grp_fill     = 0;
                grp_unstable = 1'b0;
                return 1'b0;
            end
            lbd_pkg::CMD_NOP: return 1'b0;
            default: ;
        endcase

        m = ladder_mask(w);
        if (grp_fill == 0) begin
            grp_first    = m;
            grp_unstable = 1'b0;
            grp_time     = w.now;
        end else if (m != grp_first) begin
            grp_unstable = 1'b1;
        end
        grp_fill++;
        if (grp_fill < lbd_pkg::SAMPLES_PER_UPDATE) return 1'b0;
        grp_fill = 0;

        pressed  = '0;
        released = '0;
        if (!grp_unstable) begin
            if (grp_first != last_read) begin
                deb_start = grp_time;
                last_read = grp_first;
            end
            // wrapping time difference against the debounce length
            if (grp_time - deb_start > 32'(debounce_len) && grp_first != deb_mask) begin
                pressed  = grp_first & ~deb_mask;
                released = deb_mask & ~grp_first;
                if (pressed != '0 && deb_mask == '0) press_start = grp_time;
                if (released != '0 && grp_first == '0) press_finish = grp_time;
                deb_mask = grp_first;
            end
        end
        pressed      |= inject_queue;
        inject_queue  = '0;

        r.pressed  = pressed;
        r.released = released;
        r.held     = deb_mask;
        r.held_ms  = (deb_mask != '0) ? w.now - press_start : press_finish - press_start;
        r.stable   = !grp_unstable;
        return 1'b1;
    endfunction

    // a reading that lands on an extreme, near a range bound, or anywhere
    function automatic logic [11:0] pick_level();
        logic [11:0] bound;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            1: begin
                case ($urandom_range(0, 4))
                    0: bound = lvl_no_button;
                    1: bound = lvl_a;
                    2: bound = lvl_b;
                    3: bound = lvl_c;
                    default: bound = lvl_2;
                endcase
                return bound + 12'($urandom_range(0, 120)) - 12'd60;
            end
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic cfg_set_t setting_for(input int phase);
        cfg_set_t c;
        c = '{16'd3800, 16'd3100, 16'd2090, 16'd750, 16'd1120, 16'd50, 16'd5};
        case (phase)
            0: c.debounce = 16'($urandom_range(0, 20));
            1: c = '0;                                // everything at the bottom
            2: c = '1;                                // everything at the top, upper bits too
            3: begin                                  // random but in order
                c.level    = 16'($urandom_range(3000, 4095));
                c.thr_a    = 16'($urandom_range(2000, c.level));
                c.thr_b    = 16'($urandom_range(800, c.thr_a));
                c.thr_c    = 16'($urandom_range(0, c.thr_b));
                c.thr_2    = 16'($urandom_range(0, c.level));
                c.guard    = 16'($urandom_range(0, 150));
                c.debounce = 16'($urandom_range(0, 40));
            end
            4: c = {$urandom, $urandom, $urandom, 16'($urandom)};  // random, in any order
            default: begin
                c.guard    = 16'($urandom_range(0, 100));
                c.debounce = 16'($urandom_range(1, 10));
            end
        endcase
        return c;
    endfunction

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [lbd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            lbd_pkg::CFG_NO_BUTTON_LEVEL: lvl_no_button = data[11:0];
            lbd_pkg::CFG_LADDER1_THR_A:   lvl_a         = data[11:0];
            lbd_pkg::CFG_LADDER1_THR_B:   lvl_b         = data[11:0];
            lbd_pkg::CFG_LADDER1_THR_C:   lvl_c         = data[11:0];
            lbd_pkg::CFG_LADDER2_THR:     lvl_2         = data[11:0];
            lbd_pkg::CFG_GUARD_BAND:      guard_width   = data[11:0];
            lbd_pkg::CFG_DEBOUNCE_MS:     debounce_len  = data;
            default: ;
        endcase
    endtask

    // present one word and hold it until taken, then predict its result
    task automatic send_word(input sample_word_t w, input bit use_typed, input report_t typed);
        report_t r;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_command     <= w.cmd;
        s_adc_ladder1 <= w.adc1;
        s_adc_ladder2 <= w.adc2;
        s_power_low   <= w.pwr;
        s_now_ms      <= w.now;
        s_button      <= w.button;
        do @(posedge aclk); while (!s_ready);
        if (decode_and_debounce(w, r)) reports_due.push_back(use_typed ? typed : r);
    endtask

    task automatic idle_gap(input int unsigned n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // wait for every predicted result, then let the pipeline empty
    task automatic drain_reports();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // result checker: every taken result word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h %h %h %h %b",
                         $time, m_pressed, m_released, m_held_now, m_held_ms,
                         m_reading_stable);
                mismatches++;
            end else begin
                front = reports_due.pop_front();
                check_field("pressed", 32'(front.pressed), 32'(m_pressed));
                check_field("released", 32'(front.released), 32'(m_released));
                check_field("held_now", 32'(front.held), 32'(m_held_now));
                check_field("held_ms", front.held_ms, m_held_ms);
                check_field("reading_stable", 32'(front.stable), 32'(m_reading_stable));
            end
        end
    end

    initial begin
        sample_word_t w;
        cfg_set_t     cs;
        logic [31:0]  cur_ms;
        logic [11:0]  hold_adc1;
        logic [11:0]  hold_adc2;
        logic         hold_pwr;
        int           words;
        int           sel;
        int           step;
        bit           noisy;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // directed words under the reset register values
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 16));
            send_word(SCRIPT[r].word, SCRIPT[r].typed, SCRIPT[r].want);
        end
        drain_reports();

        for (int phase = 0; phase < PHASES; phase++) begin
            // block is idle here: load a full setting
            cs = setting_for(phase);
            write_reg(lbd_pkg::CFG_NO_BUTTON_LEVEL, cs.level);
            write_reg(lbd_pkg::CFG_LADDER1_THR_A, cs.thr_a);
            write_reg(lbd_pkg::CFG_LADDER1_THR_B, cs.thr_b);
            write_reg(lbd_pkg::CFG_LADDER1_THR_C, cs.thr_c);
            write_reg(lbd_pkg::CFG_LADDER2_THR, cs.thr_2);
            write_reg(lbd_pkg::CFG_GUARD_BAND, cs.guard);
            write_reg(lbd_pkg::CFG_DEBOUNCE_MS, cs.debounce);
            @(negedge aclk);
            cfg_wr_en <= 1'b0;

            cur_ms    = $urandom;
            hold_adc1 = pick_level();
            hold_adc2 = pick_level();
            hold_pwr  = 1'($urandom_range(0, 1));
            words     = 0;
            while (words < PHASE_WORDS) begin
                // idling comes and goes, and stays off in the last phase
                if (words % 40 == 0)
                    idle_en = (phase != PHASES - 1) && ($urandom_range(0, 2) != 0);
                if (idle_en && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 16));

                // the buttons change now and then, so most groups come out stable
                if ($urandom_range(0, 24) == 0) begin
                    hold_adc1 = pick_level();
                    hold_adc2 = pick_level();
                    hold_pwr  = 1'($urandom_range(0, 1));
                end

                // mostly small time steps, some past the debounce length, a few anywhere
                step = $urandom_range(0, 99);
                if (step < 85)
                    cur_ms += $urandom_range(0, 3);
                else if (step < 97)
                    cur_ms += $urandom_range(0, 2 * debounce_len + 2);
                else
                    cur_ms += $urandom;

                sel   = $urandom_range(0, 99);
                w.cmd = (sel < 84) ? lbd_pkg::CMD_SAMPLE :
                        (sel < 91) ? lbd_pkg::CMD_INJECT :
                        (sel < 95) ? lbd_pkg::CMD_FLUSH  : lbd_pkg::CMD_NOP;
                noisy    = ($urandom_range(0, 99) < 8);
                w.adc1   = noisy ? 12'($urandom) : hold_adc1;
                w.adc2   = noisy ? 12'($urandom) : hold_adc2;
                w.pwr    = noisy ? 1'($urandom_range(0, 1)) : hold_pwr;
                w.now    = cur_ms;
                w.button = 3'($urandom_range(0, 7));
                send_word(w, 1'b0, NO_REPORT);
                if (w.cmd != lbd_pkg::CMD_NOP) words++;
            end
            drain_reports();
        end

        if (mismatches == 0)
            $display("PASS ladder_button_debouncer");
        else
            $display("FAIL ladder_button_debouncer");
        $finish;
    end

endmodule
